// ===== hw/rtl/rag_pkg.sv =====
package rag_pkg;

  // Field widths
  localparam int POS_W   = 12;
  localparam int CH_W    = 8;
  localparam int DISC_W  = 13;
  localparam int FADE_W  = 9;
  localparam int ALPHA_W = 8;

  // Parameter defaults
  localparam int MAX_SIZE_DEF       = 4096;
  localparam int DIST_FRAC_BITS_DEF = 8;

  // Fully transparent fade
  localparam logic [FADE_W-1:0] FADE_FULL = 9'd256;

  // Register map
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_DISC_SIZE  = 3'd0;
  localparam logic [IDX_W-1:0] REG_FADE       = 3'd1;
  localparam logic [IDX_W-1:0] REG_FILL_RED   = 3'd2;
  localparam logic [IDX_W-1:0] REG_FILL_GREEN = 3'd3;
  localparam logic [IDX_W-1:0] REG_FILL_BLUE  = 3'd4;

  localparam logic [DISC_W-1:0] DISC_SIZE_RST = 13'd128;

  // Pixel side data that rides along with the distance math
  typedef struct packed {
    logic            pass;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } pix_t;

  localparam int PIX_W = $bits(pix_t);

endpackage

// ===== hw/rtl/radial_alpha_gradient.sv =====
// Radial alpha gradient: one RGBA pixel with its (pos_x, pos_y) goes in on a
// start pulse and comes back on the done strobe. The block takes a request
// every cycle (busy is high only during reset) and the receiver cannot stall:
// done is high for exactly one cycle per request, in request order. A request
// passes the capture, axis distance, squares and squared distance stages, the
// pipelined square root (one root bit per stage; the root is ROOT_W bits, 21
// at the default MAX_SIZE and DIST_FRAC_BITS), the falloff numerator stage,
// the 8-stage alpha divider and the output register. Black pixels get the
// fill color and an alpha that falls off linearly from 255 at the disc center
// to 0 at the radius, then scaled by (256 - fade) / 256; other pixels, and
// every pixel when disc_size is 0 or 1, pass through. Registers sit on an APB
// port at byte offsets 0x00 disc_size, 0x04 fade, 0x08/0x0C/0x10 fill
// red/green/blue; write them only while no request is in flight.
module radial_alpha_gradient #(
  parameter int MAX_SIZE       = rag_pkg::MAX_SIZE_DEF,
  parameter int DIST_FRAC_BITS = rag_pkg::DIST_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // pixel requests
  input  logic                        start,
  output logic                        busy,
  input  logic [rag_pkg::POS_W-1:0]   pos_x,
  input  logic [rag_pkg::POS_W-1:0]   pos_y,
  input  logic [rag_pkg::CH_W-1:0]    red_in,
  input  logic [rag_pkg::CH_W-1:0]    green_in,
  input  logic [rag_pkg::CH_W-1:0]    blue_in,
  input  logic [rag_pkg::CH_W-1:0]    alpha_in,
  // results
  output logic                        done,
  output logic [rag_pkg::CH_W-1:0]    red_out,
  output logic [rag_pkg::CH_W-1:0]    green_out,
  output logic [rag_pkg::CH_W-1:0]    blue_out,
  output logic [rag_pkg::CH_W-1:0]    alpha_out,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rag_pkg::ADDR_W-1:0]  paddr,
  input  logic [rag_pkg::DATA_W-1:0]  pwdata,
  output logic [rag_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  import rag_pkg::*;

  // Widths that follow from the disc size and the distance precision
  localparam int SIZE_W_RAW = $clog2(MAX_SIZE + 1);
  localparam int SIZE_W     = (SIZE_W_RAW > DISC_W) ? SIZE_W_RAW : DISC_W;
  localparam int RAD_W      = $clog2(MAX_SIZE / 2 + 1);
  localparam int DX_W       = (RAD_W > POS_W) ? RAD_W : POS_W;
  localparam int SQ_W       = 2 * DX_W;
  localparam int SUM_W      = SQ_W + 1;
  localparam int Q_W        = SUM_W + 2 * DIST_FRAC_BITS;
  localparam int ROOT_W     = (Q_W + 1) / 2;
  localparam int RADC_W     = 2 * ROOT_W;
  localparam int RQ_W       = RAD_W + DIST_FRAC_BITS;
  localparam int CMP_W      = (ROOT_W > RQ_W) ? ROOT_W : RQ_W;
  localparam int NUM_W      = RQ_W + ALPHA_W;
  localparam int PROD_W     = ALPHA_W + FADE_W;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [DISC_W-1:0] disc_size;
  logic [FADE_W-1:0] fade;
  logic [CH_W-1:0]   fill_red;
  logic [CH_W-1:0]   fill_green;
  logic [CH_W-1:0]   fill_blue;

  logic              cfg_wr;
  logic [IDX_W-1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      disc_size  <= DISC_SIZE_RST;
      fade       <= '0;
      fill_red   <= '0;
      fill_green <= '0;
      fill_blue  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DISC_SIZE:  disc_size  <= pwdata[DISC_W-1:0];
        REG_FADE:       fade       <= pwdata[FADE_W-1:0];
        REG_FILL_RED:   fill_red   <= pwdata[CH_W-1:0];
        REG_FILL_GREEN: fill_green <= pwdata[CH_W-1:0];
        REG_FILL_BLUE:  fill_blue  <= pwdata[CH_W-1:0];
        default: ;  // drop writes to unmapped offsets
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DISC_SIZE:  prdata = DATA_W'(disc_size);
      REG_FADE:       prdata = DATA_W'(fade);
      REG_FILL_RED:   prdata = DATA_W'(fill_red);
      REG_FILL_GREEN: prdata = DATA_W'(fill_green);
      REG_FILL_BLUE:  prdata = DATA_W'(fill_blue);
      default:        prdata = '0;
    endcase
  end

  // Derived geometry; the user keeps it static while requests are in flight (not enforced here).
  logic [SIZE_W-1:0] disc_ext;
  logic [SIZE_W-1:0] size_clamped;
  logic [RAD_W-1:0]  radius;
  logic [RQ_W-1:0]   radius_q;
  logic [FADE_W-1:0] fade_clamped;
  logic [FADE_W-1:0] fade_scale;

  always_comb begin
    disc_ext     = SIZE_W'(disc_size);
    size_clamped = (disc_ext > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : disc_ext;
    radius       = RAD_W'(size_clamped >> 1);
    radius_q     = RQ_W'(radius) << DIST_FRAC_BITS;
    fade_clamped = (fade > FADE_FULL) ? FADE_FULL : fade;
    fade_scale   = FADE_FULL - fade_clamped;
  end

  // Every cycle takes a request; hold off only during reset.
  assign busy = rst;

  // ---------------------------------------------------------------------
  // Stage 1: capture the request
  // ---------------------------------------------------------------------
  logic              s1_vld;
  logic [POS_W-1:0]  s1_px;
  logic [POS_W-1:0]  s1_py;
  logic [CH_W-1:0]   s1_r;
  logic [CH_W-1:0]   s1_g;
  logic [CH_W-1:0]   s1_b;
  logic [CH_W-1:0]   s1_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_px <= pos_x;
    s1_py <= pos_y;
    s1_r  <= red_in;
    s1_g  <= green_in;
    s1_b  <= blue_in;
    s1_a  <= alpha_in;
  end

  // ---------------------------------------------------------------------
  // Stage 2: distance to the center on each axis, pass-through decision
  // ---------------------------------------------------------------------
  logic [DX_W-1:0] px_ext;
  logic [DX_W-1:0] py_ext;
  logic [DX_W-1:0] rad_ext;
  logic [DX_W-1:0] dx_next;
  logic [DX_W-1:0] dy_next;
  pix_t            pix_next;

  always_comb begin
    px_ext  = DX_W'(s1_px);
    py_ext  = DX_W'(s1_py);
    rad_ext = DX_W'(radius);
    dx_next = (px_ext >= rad_ext) ? (px_ext - rad_ext) : (rad_ext - px_ext);
    dy_next = (py_ext >= rad_ext) ? (py_ext - rad_ext) : (rad_ext - py_ext);
    // only black pixels get repainted, and only when the disc radius is nonzero
    pix_next.pass  = (radius == '0) | (s1_r != '0) | (s1_g != '0) | (s1_b != '0);
    pix_next.red   = s1_r;
    pix_next.green = s1_g;
    pix_next.blue  = s1_b;
    pix_next.alpha = s1_a;
  end

  logic            s2_vld;
  logic [DX_W-1:0] s2_dx;
  logic [DX_W-1:0] s2_dy;
  pix_t            s2_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_dx  <= dx_next;
    s2_dy  <= dy_next;
    s2_pix <= pix_next;
  end

  // ---------------------------------------------------------------------
  // Stage 3: squares
  // ---------------------------------------------------------------------
  logic            s3_vld;
  logic [SQ_W-1:0] s3_sqx;
  logic [SQ_W-1:0] s3_sqy;
  pix_t            s3_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    s3_sqx <= SQ_W'(s2_dx) * SQ_W'(s2_dx);
    s3_sqy <= SQ_W'(s2_dy) * SQ_W'(s2_dy);
    s3_pix <= s2_pix;
  end

  // ---------------------------------------------------------------------
  // Stage 4: squared distance
  // ---------------------------------------------------------------------
  logic             s4_vld;
  logic [SUM_W-1:0] s4_sum;
  pix_t             s4_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    s4_sum <= SUM_W'(s3_sqx) + SUM_W'(s3_sqy);
    s4_pix <= s3_pix;
  end

  // ---------------------------------------------------------------------
  // Square root: distance in fixed point with DIST_FRAC_BITS fraction bits
  // ---------------------------------------------------------------------
  logic [RADC_W-1:0] radicand;
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  logic [PIX_W-1:0]  sq_tag;
  pix_t              sq_pix;

  assign radicand = RADC_W'(s4_sum) << (2 * DIST_FRAC_BITS);

  rag_isqrt #(
    .RAD_W (RADC_W),
    .TAG_W (PIX_W)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s4_vld),
    .radicand  (radicand),
    .in_tag    (s4_pix),
    .out_valid (sq_vld),
    .root      (sq_root),
    .out_tag   (sq_tag)
  );

  assign sq_pix = pix_t'(sq_tag);

  // ---------------------------------------------------------------------
  // Stage 5: falloff numerator 255 * (R - d), zero at or beyond the radius
  // ---------------------------------------------------------------------
  logic [CMP_W-1:0] d_ext;
  logic [CMP_W-1:0] rq_ext;
  logic [RQ_W-1:0]  gap;
  logic [NUM_W-1:0] num_next;

  always_comb begin
    d_ext  = CMP_W'(sq_root);
    rq_ext = CMP_W'(radius_q);
    gap    = RQ_W'(rq_ext - d_ext);
    if (d_ext < rq_ext) begin
      num_next = (NUM_W'(gap) << ALPHA_W) - NUM_W'(gap);
    end else begin
      num_next = '0;
    end
  end

  logic             s5_vld;
  logic [NUM_W-1:0] s5_num;
  pix_t             s5_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else begin
      s5_vld <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    s5_num <= num_next;
    s5_pix <= sq_pix;
  end

  // ---------------------------------------------------------------------
  // Divide by R: linear alpha in 0..255
  // ---------------------------------------------------------------------
  logic               dv_vld;
  logic [ALPHA_W-1:0] dv_alpha;
  logic [PIX_W-1:0]   dv_tag;
  pix_t               dv_pix;

  rag_div #(
    .DIV_W (RQ_W),
    .QUO_W (ALPHA_W),
    .TAG_W (PIX_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s5_vld),
    .dividend  (s5_num),
    .divisor   (radius_q),
    .in_tag    (s5_pix),
    .out_valid (dv_vld),
    .quotient  (dv_alpha),
    .out_tag   (dv_tag)
  );

  assign dv_pix = pix_t'(dv_tag);

  // ---------------------------------------------------------------------
  // Output stage: apply fade, pick fill or pass-through
  // ---------------------------------------------------------------------
  logic [PROD_W-1:0] faded;

  assign faded = PROD_W'(dv_alpha) * PROD_W'(fade_scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_pix.pass) begin
      red_out   <= dv_pix.red;
      green_out <= dv_pix.green;
      blue_out  <= dv_pix.blue;
      alpha_out <= dv_pix.alpha;
    end else begin
      red_out   <= fill_red;
      green_out <= fill_green;
      blue_out  <= fill_blue;
      alpha_out <= faded[ALPHA_W +: CH_W];
    end
  end

endmodule

// ===== hw/rtl/rag_isqrt.sv =====
module rag_isqrt #(
  parameter int RAD_W = 42,
  parameter int TAG_W = 33
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [RAD_W-1:0]   radicand,
  input  logic [TAG_W-1:0]   in_tag,
  output logic               out_valid,
  output logic [RAD_W/2-1:0] root,
  output logic [TAG_W-1:0]   out_tag
);

  // One root bit per stage, digit-by-digit restoring square root.
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int SH_W   = REM_W + 2;

  logic [ROOT_W-1:0] vld;
  logic [RAD_W-1:0]  rad  [ROOT_W];
  logic [ROOT_W-1:0] rt   [ROOT_W];
  logic [REM_W-1:0]  rm   [ROOT_W];
  logic [TAG_W-1:0]  tg   [ROOT_W];

  logic              c_vld  [ROOT_W];
  logic [RAD_W-1:0]  c_rad  [ROOT_W];
  logic [ROOT_W-1:0] c_rt   [ROOT_W];
  logic [REM_W-1:0]  c_rm   [ROOT_W];
  logic [TAG_W-1:0]  c_tg   [ROOT_W];
  logic [SH_W-1:0]   rem_sh [ROOT_W];
  logic [SH_W-1:0]   trial  [ROOT_W];
  logic              take   [ROOT_W];

  always_comb begin
    for (int i = 0; i < ROOT_W; i++) begin
      if (i == 0) begin
        c_vld[i] = in_valid;
        c_rad[i] = radicand;
        c_rt[i]  = '0;
        c_rm[i]  = '0;
        c_tg[i]  = in_tag;
      end else begin
        c_vld[i] = vld[i-1];
        c_rad[i] = rad[i-1];
        c_rt[i]  = rt[i-1];
        c_rm[i]  = rm[i-1];
        c_tg[i]  = tg[i-1];
      end
      // bring down the next pair of radicand bits
      rem_sh[i] = {c_rm[i], c_rad[i][RAD_W-1-2*i -: 2]};
      trial[i]  = SH_W'({c_rt[i], 2'b01});
      take[i]   = (rem_sh[i] >= trial[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < ROOT_W; i++) begin
        vld[i] <= c_vld[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ROOT_W; i++) begin
      rad[i] <= c_rad[i];
      rt[i]  <= {c_rt[i][ROOT_W-2:0], take[i]};
      rm[i]  <= take[i] ? REM_W'(rem_sh[i] - trial[i]) : REM_W'(rem_sh[i]);
      tg[i]  <= c_tg[i];
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign root      = rt[ROOT_W-1];
  assign out_tag   = tg[ROOT_W-1];

endmodule

// ===== hw/rtl/rag_div.sv =====
module rag_div #(
  parameter int DIV_W = 20,
  parameter int QUO_W = 8,
  parameter int TAG_W = 33
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [DIV_W+QUO_W-1:0] dividend,
  input  logic [DIV_W-1:0]       divisor,
  input  logic [TAG_W-1:0]       in_tag,
  output logic                   out_valid,
  output logic [QUO_W-1:0]       quotient,
  output logic [TAG_W-1:0]       out_tag
);

  // One quotient bit per stage; dividend must be below divisor << QUO_W.
  // The user must hold the divisor steady while requests are in flight; the block does not enforce it.
  localparam int NUM_W = DIV_W + QUO_W;

  logic [QUO_W-1:0] vld;
  logic [NUM_W-1:0] rm [QUO_W];
  logic [QUO_W-1:0] qo [QUO_W];
  logic [TAG_W-1:0] tg [QUO_W];

  logic             c_vld [QUO_W];
  logic [NUM_W-1:0] c_rm  [QUO_W];
  logic [QUO_W-1:0] c_qo  [QUO_W];
  logic [TAG_W-1:0] c_tg  [QUO_W];
  logic [NUM_W-1:0] dsh   [QUO_W];
  logic             take  [QUO_W];

  always_comb begin
    for (int i = 0; i < QUO_W; i++) begin
      if (i == 0) begin
        c_vld[i] = in_valid;
        c_rm[i]  = dividend;
        c_qo[i]  = '0;
        c_tg[i]  = in_tag;
      end else begin
        c_vld[i] = vld[i-1];
        c_rm[i]  = rm[i-1];
        c_qo[i]  = qo[i-1];
        c_tg[i]  = tg[i-1];
      end
      dsh[i]  = NUM_W'(divisor) << (QUO_W - 1 - i);
      take[i] = (c_rm[i] >= dsh[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < QUO_W; i++) begin
        vld[i] <= c_vld[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUO_W; i++) begin
      rm[i] <= take[i] ? (c_rm[i] - dsh[i]) : c_rm[i];
      qo[i] <= {c_qo[i][QUO_W-2:0], take[i]};
      tg[i] <= c_tg[i];
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign quotient  = qo[QUO_W-1];
  assign out_tag   = tg[QUO_W-1];

endmodule
